>>> rtl/core/ip_flow_byte_accounting_defines.svh
// Assertion macros shared by the flow accounting RTL.
// No dependencies; include after the timescale line of a module file.
`ifndef IP_FLOW_BYTE_ACCOUNTING_DEFINES_SVH
`define IP_FLOW_BYTE_ACCOUNTING_DEFINES_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ipfba_pkg.sv
// Shared types and constants of the flow byte accounting block.
// No dependencies; compile first.
`timescale 1ns / 1ps

package ipfba_pkg;

  localparam int DEF_FLOW_ENTRIES = 32;
  localparam int DEF_COUNT_BITS   = 48;

  localparam int ADDR_BITS      = 32;
  localparam int LEN_BITS       = 16;
  localparam int HINT_BITS      = 2;
  localparam int OUT_COUNT_BITS = 48;
  localparam int SLOT_BITS      = 5;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 1;

  localparam logic                 CMD_REPORT    = 1'b1;
  localparam logic [HINT_BITS-1:0] HINT_INCOMING = 2'd0;
  localparam logic [HINT_BITS-1:0] HINT_LEAVING  = 2'd1;

  typedef enum logic [1:0] {
    KIND_STATUS  = 2'd0,
    KIND_ENTRY   = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_WATCH_ADDR    = 1'b0,
    REG_WATCH_ADDR_OK = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                 command;
    logic [ADDR_BITS-1:0] src_ip;
    logic [ADDR_BITS-1:0] dst_ip;
    logic [LEN_BITS-1:0]  ip_total_len;
    logic [HINT_BITS-1:0] hw_direction;
  } pkt_in_t;

  typedef struct packed {
    kind_t                     kind;
    logic [ADDR_BITS-1:0]      peer_addr;
    logic [ADDR_BITS-1:0]      host_addr;
    logic [OUT_COUNT_BITS-1:0] recv_bytes;
    logic [OUT_COUNT_BITS-1:0] sent_bytes;
    logic [SLOT_BITS-1:0]      slot;
    logic                      new_flow;
    logic                      overflow;
    logic                      last;
  } res_out_t;

  typedef struct packed {
    logic [ADDR_BITS-1:0] peer_addr;
    logic [ADDR_BITS-1:0] host_addr;
  } flow_key_t;

  // Broadcast control from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                lookup;
    logic                insert;
    logic                shift_down;
    logic                leaving;
    logic [LEN_BITS-1:0] len;
  } cell_ctrl_t;

endpackage

>>> rtl/core/ip_flow_byte_accounting.sv
// Top level of the per-flow IPv4 byte accounting table.
// Depends on ipfba_pkg, ipfba_chain and the assertion macro header.
`timescale 1ns / 1ps
`include "ip_flow_byte_accounting_defines.svh"

// Usage:
//   in_*   valid/ready channel of packet items and report commands (pkt_in_t).
//   out_*  valid/ready channel of result items (res_out_t), one output register.
//   cfg_*  plain write port for watch_addr and watch_addr_ok; write while idle.
// A packet transfer yields one status result: first the key compare in every
// cell (ST_LOOK), then collecting the hit counters through the OR tree or
// inserting the new flow at the head of the chain (ST_COLLECT). A new packet
// can be accepted while the result of the last one is loaded, not before.
// A report command drains the chain from the head (newest first), one entry per
// cycle while the receiver takes them, then gives the summary with the saturated
// totals: entries + 1 results, ready held low until the summary is out.
// Reset empties the table (valid bits in every cell) and clears the config.
// When the receiver stalls, the result register holds and the block waits;
// a packet accepted meanwhile finishes its compare and then holds too.

module ip_flow_byte_accounting import ipfba_pkg::*; #(
  parameter  int FLOW_ENTRIES = DEF_FLOW_ENTRIES,
  parameter  int COUNT_BITS   = DEF_COUNT_BITS,
  localparam int IDX_BITS     = $clog2(FLOW_ENTRIES),
  localparam int CNT_BITS     = $clog2(FLOW_ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  pkt_in_t                  in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output res_out_t                 out_data,
  input  logic                     cfg_write,
  input  cfg_reg_t                 cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_COLLECT,
    ST_REPORT
  } state_t;

  state_t                state;
  logic [CNT_BITS-1:0]   count;
  logic [ADDR_BITS-1:0]  watch_addr;
  logic                  watch_addr_ok;
  flow_key_t             key_q;
  logic [LEN_BITS-1:0]   len_q;
  logic                  leaving_q;
  logic [COUNT_BITS-1:0] rx_sum;
  logic [COUNT_BITS-1:0] tx_sum;
  logic [ADDR_BITS-1:0]  dev_sum;

  cell_ctrl_t            ctrl;
  logic                  any_hit;
  logic [COUNT_BITS-1:0] hit_recv;
  logic [COUNT_BITS-1:0] hit_sent;
  logic [IDX_BITS-1:0]   hit_pos;
  flow_key_t             head_key;
  logic [COUNT_BITS-1:0] head_recv;
  logic [COUNT_BITS-1:0] head_sent;

  logic                  out_free;
  logic                  load_out;
  logic                  in_fire;
  logic                  has_room;
  logic                  leaving_in;
  logic [COUNT_BITS:0]   rx_add;
  logic [COUNT_BITS:0]   tx_add;

  assign out_free = !out_valid || out_ready;
  assign load_out = ((state == ST_COLLECT) || (state == ST_REPORT)) && out_free;
  assign in_ready = (state == ST_IDLE) || ((state == ST_COLLECT) && out_free);
  assign in_fire  = in_valid && in_ready;
  assign has_room = count < CNT_BITS'(FLOW_ENTRIES);

  // Direction: the hint wins; unknown hints compare the source with watch_addr.
  assign leaving_in = (in_data.hw_direction == HINT_LEAVING) ||
                      ((in_data.hw_direction != HINT_INCOMING) &&
                       (in_data.hw_direction != HINT_LEAVING) &&
                       watch_addr_ok && (in_data.src_ip == watch_addr));

  assign rx_add = {1'b0, rx_sum} + {1'b0, head_recv};
  assign tx_add = {1'b0, tx_sum} + {1'b0, head_sent};

  always_comb begin
    ctrl.lookup     = (state == ST_LOOK);
    ctrl.insert     = (state == ST_COLLECT) && out_free && !any_hit && has_room;
    ctrl.shift_down = (state == ST_REPORT) && out_free && (count != '0);
    ctrl.leaving    = leaving_q;
    ctrl.len        = len_q;
  end

  ipfba_chain #(
    .FLOW_ENTRIES(FLOW_ENTRIES),
    .COUNT_BITS  (COUNT_BITS)
  ) u_chain (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .key       (key_q),
    .any_hit   (any_hit),
    .hit_recv  (hit_recv),
    .hit_sent  (hit_sent),
    .hit_pos   (hit_pos),
    .head_key  (head_key),
    .head_recv (head_recv),
    .head_sent (head_sent)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      out_valid     <= 1'b0;
      watch_addr    <= '0;
      watch_addr_ok <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WATCH_ADDR:    watch_addr    <= cfg_data;
          REG_WATCH_ADDR_OK: watch_addr_ok <= cfg_data[0];
        endcase
      end

      // Raise valid on a new load; drop it once the receiver takes the result.
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      // Capture the flow key and start fresh report totals.
      if (in_fire) begin
        key_q.peer_addr <= leaving_in ? in_data.dst_ip : in_data.src_ip;
        key_q.host_addr <= leaving_in ? in_data.src_ip : in_data.dst_ip;
        len_q           <= in_data.ip_total_len;
        leaving_q       <= leaving_in;
        rx_sum          <= '0;
        tx_sum          <= '0;
        dev_sum         <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            state <= (in_data.command == CMD_REPORT) ? ST_REPORT : ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_COLLECT;
        end
        ST_COLLECT: begin
          if (out_free) begin
            out_data.kind      <= KIND_STATUS;
            out_data.peer_addr <= key_q.peer_addr;
            out_data.host_addr <= key_q.host_addr;
            out_data.last      <= 1'b1;
            if (any_hit) begin
              out_data.recv_bytes <= OUT_COUNT_BITS'(hit_recv);
              out_data.sent_bytes <= OUT_COUNT_BITS'(hit_sent);
              out_data.slot       <= SLOT_BITS'(count - CNT_BITS'(1) - CNT_BITS'(hit_pos));
              out_data.new_flow   <= 1'b0;
              out_data.overflow   <= 1'b0;
            end else if (has_room) begin
              out_data.recv_bytes <= leaving_q ? '0 : OUT_COUNT_BITS'(len_q);
              out_data.sent_bytes <= leaving_q ? OUT_COUNT_BITS'(len_q) : '0;
              out_data.slot       <= SLOT_BITS'(count);
              out_data.new_flow   <= 1'b1;
              out_data.overflow   <= 1'b0;
              count               <= count + CNT_BITS'(1);
            end else begin
              out_data.recv_bytes <= '0;
              out_data.sent_bytes <= '0;
              out_data.slot       <= '0;
              out_data.new_flow   <= 1'b0;
              out_data.overflow   <= 1'b1;
            end
            if (in_fire) begin
              state <= (in_data.command == CMD_REPORT) ? ST_REPORT : ST_LOOK;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_REPORT: begin
          if (out_free) begin
            out_data.new_flow <= 1'b0;
            out_data.overflow <= 1'b0;
            if (count != '0) begin
              // Emit the head entry, fold it into the totals, advance the chain.
              out_data.kind       <= KIND_ENTRY;
              out_data.peer_addr  <= head_key.peer_addr;
              out_data.host_addr  <= head_key.host_addr;
              out_data.recv_bytes <= OUT_COUNT_BITS'(head_recv);
              out_data.sent_bytes <= OUT_COUNT_BITS'(head_sent);
              out_data.slot       <= SLOT_BITS'(count - CNT_BITS'(1));
              out_data.last       <= 1'b0;
              rx_sum              <= rx_add[COUNT_BITS] ? '1 : rx_add[COUNT_BITS-1:0];
              tx_sum              <= tx_add[COUNT_BITS] ? '1 : tx_add[COUNT_BITS-1:0];
              dev_sum             <= head_key.host_addr;
              count               <= count - CNT_BITS'(1);
            end else begin
              out_data.kind       <= KIND_SUMMARY;
              out_data.peer_addr  <= '0;
              out_data.host_addr  <= dev_sum;
              out_data.recv_bytes <= OUT_COUNT_BITS'(rx_sum);
              out_data.sent_bytes <= OUT_COUNT_BITS'(tx_sum);
              out_data.slot       <= '0;
              out_data.last       <= 1'b1;
              state               <= ST_IDLE;
            end
          end
        end
      endcase
    end
  end

  `ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_BITS'(FLOW_ENTRIES),
              "entry count beyond table size")
  `ASSERT_IMP(a_overflow_full, clk, rst, out_valid && out_data.overflow,
              count == CNT_BITS'(FLOW_ENTRIES), "overflow reported with free slots")
  `ASSERT_NEXT(a_report_drains, clk, rst, state == ST_REPORT, count <= $past(count),
               "entry count grew during a report")

endmodule

>>> rtl/core/ipfba_cell.sv
// One flow table entry: key, counters and valid bit, with neighbor shift paths.
// Depends on ipfba_pkg.
`timescale 1ns / 1ps

module ipfba_cell import ipfba_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  flow_key_t             key,
  input  logic                  up_valid,
  input  flow_key_t             up_key,
  input  logic [COUNT_BITS-1:0] up_recv,
  input  logic [COUNT_BITS-1:0] up_sent,
  input  logic                  dn_valid,
  input  flow_key_t             dn_key,
  input  logic [COUNT_BITS-1:0] dn_recv,
  input  logic [COUNT_BITS-1:0] dn_sent,
  output logic                  valid,
  output flow_key_t             ekey,
  output logic [COUNT_BITS-1:0] recv,
  output logic [COUNT_BITS-1:0] sent,
  output logic                  match
);

  logic                  hit;
  logic [COUNT_BITS:0]   add_sum;
  logic [COUNT_BITS-1:0] add_sat;

  assign hit = valid && (ekey == key);

  // Saturating add of the packet length to the counter of this direction.
  always_comb begin
    add_sum = {1'b0, (ctrl.leaving ? sent : recv)} + (COUNT_BITS + 1)'(ctrl.len);
    add_sat = add_sum[COUNT_BITS] ? '1 : add_sum[COUNT_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.insert) begin
        valid <= up_valid;
      end else if (ctrl.shift_down) begin
        valid <= dn_valid;
      end
      if (ctrl.lookup) begin
        match <= hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.insert) begin
      ekey <= up_key;
      recv <= up_recv;
      sent <= up_sent;
    end else if (ctrl.shift_down) begin
      ekey <= dn_key;
      recv <= dn_recv;
      sent <= dn_sent;
    end else if (ctrl.lookup && hit) begin
      if (ctrl.leaving) begin
        sent <= add_sat;
      end else begin
        recv <= add_sat;
      end
    end
  end

endmodule

>>> rtl/core/ipfba_chain.sv
// Row of flow table cells, newest entry in cell 0, plus the hit collection.
// Depends on ipfba_pkg, ipfba_cell and the assertion macro header.
`timescale 1ns / 1ps
`include "ip_flow_byte_accounting_defines.svh"

module ipfba_chain import ipfba_pkg::*; #(
  parameter  int FLOW_ENTRIES = DEF_FLOW_ENTRIES,
  parameter  int COUNT_BITS   = DEF_COUNT_BITS,
  localparam int IDX_BITS     = $clog2(FLOW_ENTRIES)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_ctrl_t            ctrl,
  input  flow_key_t             key,
  output logic                  any_hit,
  output logic [COUNT_BITS-1:0] hit_recv,
  output logic [COUNT_BITS-1:0] hit_sent,
  output logic [IDX_BITS-1:0]   hit_pos,
  output flow_key_t             head_key,
  output logic [COUNT_BITS-1:0] head_recv,
  output logic [COUNT_BITS-1:0] head_sent
);

  logic [FLOW_ENTRIES-1:0] valid_v;
  logic [FLOW_ENTRIES-1:0] match_v;
  flow_key_t               key_v  [FLOW_ENTRIES];
  logic [COUNT_BITS-1:0]   recv_v [FLOW_ENTRIES];
  logic [COUNT_BITS-1:0]   sent_v [FLOW_ENTRIES];

  logic [COUNT_BITS-1:0] new_recv;
  logic [COUNT_BITS-1:0] new_sent;

  assign new_recv = ctrl.leaving ? '0 : COUNT_BITS'(ctrl.len);
  assign new_sent = ctrl.leaving ? COUNT_BITS'(ctrl.len) : '0;

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    logic                  up_valid;
    flow_key_t             up_key;
    logic [COUNT_BITS-1:0] up_recv;
    logic [COUNT_BITS-1:0] up_sent;
    logic                  dn_valid;
    flow_key_t             dn_key;
    logic [COUNT_BITS-1:0] dn_recv;
    logic [COUNT_BITS-1:0] dn_sent;

    // A new flow enters at cell 0; older entries move one cell up.
    if (i == 0) begin : g_head
      assign up_valid = 1'b1;
      assign up_key   = key;
      assign up_recv  = new_recv;
      assign up_sent  = new_sent;
    end else begin : g_body
      assign up_valid = valid_v[i-1];
      assign up_key   = key_v[i-1];
      assign up_recv  = recv_v[i-1];
      assign up_sent  = sent_v[i-1];
    end

    // Reporting drains toward cell 0; the far end fills with empty entries.
    if (i == FLOW_ENTRIES - 1) begin : g_tail
      assign dn_valid = 1'b0;
      assign dn_key   = '0;
      assign dn_recv  = '0;
      assign dn_sent  = '0;
    end else begin : g_link
      assign dn_valid = valid_v[i+1];
      assign dn_key   = key_v[i+1];
      assign dn_recv  = recv_v[i+1];
      assign dn_sent  = sent_v[i+1];
    end

    ipfba_cell #(
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .key      (key),
      .up_valid (up_valid),
      .up_key   (up_key),
      .up_recv  (up_recv),
      .up_sent  (up_sent),
      .dn_valid (dn_valid),
      .dn_key   (dn_key),
      .dn_recv  (dn_recv),
      .dn_sent  (dn_sent),
      .valid    (valid_v[i]),
      .ekey     (key_v[i]),
      .recv     (recv_v[i]),
      .sent     (sent_v[i]),
      .match    (match_v[i])
    );
  end

  // Keys are unique in the table, so at most one registered match is set
  // and an OR over the gated cell outputs selects the hit entry.
  always_comb begin
    hit_recv = '0;
    hit_sent = '0;
    hit_pos  = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit_recv = hit_recv | (recv_v[i] & {COUNT_BITS{match_v[i]}});
      hit_sent = hit_sent | (sent_v[i] & {COUNT_BITS{match_v[i]}});
      hit_pos  = hit_pos | (IDX_BITS'(i) & {IDX_BITS{match_v[i]}});
    end
  end

  assign any_hit   = |match_v;
  assign head_key  = key_v[0];
  assign head_recv = recv_v[0];
  assign head_sent = sent_v[0];

  `ASSERT_IMP(a_single_match, clk, rst, 1'b1, $onehot0(match_v), "two cells hold one key")
  `ASSERT_IMP(a_valid_packed, clk, rst, 1'b1,
              ((valid_v + FLOW_ENTRIES'(1)) & valid_v) == '0, "table has a hole")

endmodule

>>> bench/tb_top.sv
// Self-checking bench for the per-flow IPv4 byte accounting table.
// Depends on ipfba_pkg and the ip_flow_byte_accounting RTL; needs nothing else.
`timescale 1ns / 1ps

module tb_top;
  import ipfba_pkg::*;

  localparam int SLOTS = DEF_FLOW_ENTRIES;
  localparam logic CMD_ACCOUNT = ~CMD_REPORT;
  localparam logic [HINT_BITS-1:0] HINT_UNKNOWN     = 2'd2;
  localparam logic [HINT_BITS-1:0] HINT_UNKNOWN_ALT = 2'd3;
  // Worst case is far below this: ~480 items, reports of up to 33 results,
  // each result and each item under random stalls of at most 45 percent.
  localparam int LIMIT_CYCLES        = 400000;
  localparam int SETTLE_CYCLES       = 8;
  localparam int RANDOM_PHASES       = 8;
  localparam int ITEMS_PER_PHASE     = 43;
  localparam int REPORTED_MISMATCHES = 10;

  typedef enum {ROW_PACKET, ROW_CONFIG} row_op_t;

  // One line of the directed script: a packet or report, or a config change.
  typedef struct {
    row_op_t              op;
    pkt_in_t              pkt;
    logic [ADDR_BITS-1:0] ip;
    logic                 ip_ok;
    bit                   typed;
    res_out_t             want;
  } script_row_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  pkt_in_t                  in_data = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  res_out_t                 out_data;
  logic                     cfg_write = 1'b0;
  cfg_reg_t                 cfg_index = REG_WATCH_ADDR;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Idle percentages of the two channels, changed per phase.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int mismatches     = 0;
  int cycle_count    = 0;

  // Shadow of the flow table and of the monitored address.
  logic                      flow_live   [SLOTS];
  logic [ADDR_BITS-1:0]      flow_remote [SLOTS];
  logic [ADDR_BITS-1:0]      flow_local  [SLOTS];
  logic [OUT_COUNT_BITS-1:0] flow_rx     [SLOTS];
  logic [OUT_COUNT_BITS-1:0] flow_tx     [SLOTS];
  int                        flow_fill = 0;
  logic [ADDR_BITS-1:0]      mon_ip    = '0;
  logic                      mon_ip_ok = 1'b0;

  // Results still owed by the block, oldest first.
  res_out_t flow_results_due[$];

  ip_flow_byte_accounting DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) flow_live[i] = 1'b0;
  end

  function automatic logic [OUT_COUNT_BITS-1:0] sat_add(input logic [OUT_COUNT_BITS-1:0] a,
                                                        input logic [OUT_COUNT_BITS-1:0] b);
    logic [OUT_COUNT_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OUT_COUNT_BITS] ? {OUT_COUNT_BITS{1'b1}} : s[OUT_COUNT_BITS-1:0];
  endfunction

  function automatic res_out_t make_result(input kind_t kind,
                                           input logic [ADDR_BITS-1:0] remote,
                                           input logic [ADDR_BITS-1:0] device,
                                           input logic [OUT_COUNT_BITS-1:0] rx,
                                           input logic [OUT_COUNT_BITS-1:0] tx,
                                           input logic [SLOT_BITS-1:0] slot,
                                           input logic nf, input logic ovf,
                                           input logic fin);
    res_out_t r;
    r.kind       = kind;
    r.peer_addr  = remote;
    r.host_addr  = device;
    r.recv_bytes = rx;
    r.sent_bytes = tx;
    r.slot       = slot;
    r.new_flow   = nf;
    r.overflow   = ovf;
    r.last       = fin;
    return r;
  endfunction

  function automatic pkt_in_t make_pkt(input logic cmd, input logic [ADDR_BITS-1:0] src,
                                       input logic [ADDR_BITS-1:0] dst,
                                       input logic [LEN_BITS-1:0] len,
                                       input logic [HINT_BITS-1:0] hint);
    pkt_in_t p;
    p.command      = cmd;
    p.src_ip       = src;
    p.dst_ip       = dst;
    p.ip_total_len = len;
    p.hw_direction = hint;
    return p;
  endfunction

  function automatic pkt_in_t random_pkt(input int report_pct);
    return make_pkt(($urandom_range(99) < report_pct) ? CMD_REPORT : CMD_ACCOUNT,
                    $urandom, $urandom, $urandom_range(65535), $urandom_range(3));
  endfunction

  // Work out what one accepted item makes the block emit, and advance the
  // shadow table. Reports list live slots newest first, then the totals.
  function automatic void account_item(input pkt_in_t p, ref res_out_t batch[$]);
    logic                      leaving;
    logic [ADDR_BITS-1:0]      rem;
    logic [ADDR_BITS-1:0]      loc;
    logic [ADDR_BITS-1:0]      dev;
    logic [OUT_COUNT_BITS-1:0] rx_sum;
    logic [OUT_COUNT_BITS-1:0] tx_sum;
    int                        hit;
    batch = {};
    if (p.command == CMD_REPORT) begin
      rx_sum = '0;
      tx_sum = '0;
      dev    = '0;
      for (int i = flow_fill - 1; i >= 0; i--) begin
        if (flow_live[i]) begin
          rx_sum = sat_add(rx_sum, flow_rx[i]);
          tx_sum = sat_add(tx_sum, flow_tx[i]);
          dev    = flow_local[i];
          batch.push_back(make_result(KIND_ENTRY, flow_remote[i], flow_local[i],
                                      flow_rx[i], flow_tx[i], SLOT_BITS'(i),
                                      1'b0, 1'b0, 1'b0));
        end
      end
      // Summary carries the local address of the oldest entry.
      batch.push_back(make_result(KIND_SUMMARY, '0, dev, rx_sum, tx_sum, '0,
                                  1'b0, 1'b0, 1'b1));
      for (int i = 0; i < SLOTS; i++) flow_live[i] = 1'b0;
      flow_fill = 0;
      return;
    end

    // Hint wins when known; otherwise a source equal to the local address
    // means leaving, and everything else counts as incoming.
    if (p.hw_direction == HINT_LEAVING)
      leaving = 1'b1;
    else if (p.hw_direction == HINT_INCOMING)
      leaving = 1'b0;
    else
      leaving = mon_ip_ok && (p.src_ip == mon_ip);
    rem = leaving ? p.dst_ip : p.src_ip;
    loc = leaving ? p.src_ip : p.dst_ip;

    hit = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && flow_live[i] && flow_remote[i] == rem && flow_local[i] == loc) hit = i;
    end

    if (hit >= 0) begin
      if (leaving)
        flow_tx[hit] = sat_add(flow_tx[hit], OUT_COUNT_BITS'(p.ip_total_len));
      else
        flow_rx[hit] = sat_add(flow_rx[hit], OUT_COUNT_BITS'(p.ip_total_len));
      batch.push_back(make_result(KIND_STATUS, rem, loc, flow_rx[hit], flow_tx[hit],
                                  SLOT_BITS'(hit), 1'b0, 1'b0, 1'b1));
    end else if (flow_fill >= SLOTS) begin
      // Table full: drop the packet, report the key it would have used.
      batch.push_back(make_result(KIND_STATUS, rem, loc, '0, '0, '0, 1'b0, 1'b1, 1'b1));
    end else begin
      flow_live[flow_fill]   = 1'b1;
      flow_remote[flow_fill] = rem;
      flow_local[flow_fill]  = loc;
      flow_rx[flow_fill]     = leaving ? '0 : OUT_COUNT_BITS'(p.ip_total_len);
      flow_tx[flow_fill]     = leaving ? OUT_COUNT_BITS'(p.ip_total_len) : '0;
      batch.push_back(make_result(KIND_STATUS, rem, loc, flow_rx[flow_fill],
                                  flow_tx[flow_fill], SLOT_BITS'(flow_fill),
                                  1'b1, 1'b0, 1'b1));
      flow_fill++;
    end
  endfunction

  function automatic string show(input res_out_t r);
    return $sformatf("kind=%0d remote=%h device=%h recv=%h sent=%h slot=%0d nf=%b ovf=%b last=%b",
                     r.kind, r.peer_addr, r.host_addr, r.recv_bytes, r.sent_bytes,
                     r.slot, r.new_flow, r.overflow, r.last);
  endfunction

  task automatic check_result(input res_out_t got);
    res_out_t want;
    if (flow_results_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORTED_MISMATCHES) $display("unexpected result: %s", show(got));
      return;
    end
    want = flow_results_due.pop_front();
    if (got.kind !== want.kind || got.peer_addr !== want.peer_addr ||
        got.host_addr !== want.host_addr || got.recv_bytes !== want.recv_bytes ||
        got.sent_bytes !== want.sent_bytes || got.slot !== want.slot ||
        got.new_flow !== want.new_flow || got.overflow !== want.overflow ||
        got.last !== want.last) begin
      mismatches++;
      if (mismatches <= REPORTED_MISMATCHES)
        $display("result mismatch at cycle %0d\n  expected %s\n  actual   %s",
                 cycle_count, show(want), show(got));
    end
  endtask

  // Result side: sample the transfer on the edge, then pick the next
  // ready level at random (never stalls when the stall rate is zero).
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("ip_flow_byte_accounting: mismatch");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer. Called at a rising edge;
  // returns at the edge of the transfer, with no assignment made there yet,
  // so the next item can raise valid again without a gap.
  task automatic send_item(input pkt_in_t p, input bit typed = 1'b0,
                           input res_out_t want = '0);
    res_out_t batch[$];
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    account_item(p, batch);
    // Directed rows with a hand-written answer replace the computed one.
    if (typed) batch = '{want};
    flow_results_due = {flow_results_due, batch};
    in_valid <= 1'b1;
    in_data  <= p;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid, wait for every owed result, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (flow_results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  // Reprogram the monitored address while idle; junk fills the unused
  // upper bits of the valid register write.
  task automatic set_monitor(input logic [ADDR_BITS-1:0] ip, input logic ok,
                             input logic [CFG_DATA_BITS-1:0] junk);
    drain();
    write_reg(REG_WATCH_ADDR, ip);
    write_reg(REG_WATCH_ADDR_OK, {junk[CFG_DATA_BITS-1:1], ok});
    cfg_write <= 1'b0;
    mon_ip    = ip;
    mon_ip_ok = ok;
  endtask

  // One traffic burst closed by a report. Addresses come from a small pool
  // (including the local address) so flows hit again; fresh_pct of packets
  // use new random addresses, which fills the table and forces drops.
  task automatic run_burst(input int n, input int fresh_pct);
    logic [ADDR_BITS-1:0] pool[5];
    pkt_in_t              p;
    for (int k = 0; k < 4; k++) pool[k] = $urandom;
    pool[4] = mon_ip;
    for (int k = 0; k < n; k++) begin
      p = random_pkt(0);
      if ($urandom_range(99) >= fresh_pct) begin
        p.src_ip = pool[$urandom_range(4)];
        p.dst_ip = pool[$urandom_range(4)];
      end
      send_item(p);
    end
    p = random_pkt(100);
    send_item(p);
  endtask

  initial begin
    script_row_t script[$];
    script_row_t row;
    int          target;
    int          flavor;

    // Directed script. Hand-written answers only where obvious: empty
    // report, first insert at slot 0, a hit on it, and the table refilled
    // after a report.
    row = '{op: ROW_PACKET, pkt: '0, ip: '0, ip_ok: 1'b0, typed: 1'b0, want: '0};

    // Report on an empty table: summary only, fields of the command ignored.
    row.pkt   = make_pkt(CMD_REPORT, '1, '1, 16'hFFFF, HINT_UNKNOWN_ALT);
    row.typed = 1'b1;
    row.want  = make_result(KIND_SUMMARY, '0, '0, '0, '0, '0, 1'b0, 1'b0, 1'b1);
    script.push_back(row);
    // Extreme addresses and length, incoming by hint.
    row.pkt  = make_pkt(CMD_ACCOUNT, '0, '1, 16'hFFFF, HINT_INCOMING);
    row.want = make_result(KIND_STATUS, '0, '1, 48'hFFFF, '0, '0, 1'b1, 1'b0, 1'b1);
    script.push_back(row);
    // Same flow seen leaving: hits slot 0 and adds to the sent side.
    row.pkt  = make_pkt(CMD_ACCOUNT, '1, '0, 16'd1, HINT_LEAVING);
    row.want = make_result(KIND_STATUS, '0, '1, 48'hFFFF, 48'd1, '0, 1'b0, 1'b0, 1'b1);
    script.push_back(row);
    row.typed = 1'b0;
    // Unknown hint, local address not usable: incoming even though the
    // source equals the (zero) local address.
    row.pkt = make_pkt(CMD_ACCOUNT, '0, '0, 16'd0, HINT_UNKNOWN);
    script.push_back(row);
    row.pkt = make_pkt(CMD_ACCOUNT, 32'hC0A8_0101, 32'h0A00_0001, 16'd1500, HINT_UNKNOWN_ALT);
    script.push_back(row);
    row.op    = ROW_CONFIG;
    row.ip    = 32'h0A00_0001;
    row.ip_ok = 1'b1;
    script.push_back(row);
    row.op = ROW_PACKET;
    // Unknown hint, source is local: leaving, hits the flow inserted above.
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h0A00_0001, 32'hC0A8_0101, 16'd40, HINT_UNKNOWN);
    script.push_back(row);
    // Destination is local: incoming.
    row.pkt = make_pkt(CMD_ACCOUNT, 32'hC0A8_0101, 32'h0A00_0001, 16'd576, HINT_UNKNOWN);
    script.push_back(row);
    // Neither side local: default incoming.
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h0808_0808, 32'h0101_0101, 16'd100, HINT_UNKNOWN_ALT);
    script.push_back(row);
    // Both sides local: the source test comes first, so leaving.
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h0A00_0001, 32'h0A00_0001, 16'd60, HINT_UNKNOWN);
    script.push_back(row);
    // Known hint overrides the address comparison.
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h0A00_0001, 32'hC0A8_0101, 16'd1, HINT_INCOMING);
    script.push_back(row);
    row.pkt = make_pkt(CMD_ACCOUNT, 32'hAAAA_AAAA, 32'h5555_5555, 16'hAAAA, HINT_LEAVING);
    script.push_back(row);
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h5555_5555, 32'hAAAA_AAAA, 16'h5555, HINT_INCOMING);
    script.push_back(row);
    row.pkt = make_pkt(CMD_REPORT, '0, '0, '0, HINT_INCOMING);
    script.push_back(row);
    // Address kept but marked unusable: inference falls back to incoming.
    row.op    = ROW_CONFIG;
    row.ip_ok = 1'b0;
    script.push_back(row);
    row.op  = ROW_PACKET;
    row.pkt = make_pkt(CMD_ACCOUNT, 32'h0A00_0001, 32'hC0A8_0101, 16'd1000, HINT_UNKNOWN);
    script.push_back(row);
    row.pkt = make_pkt(CMD_REPORT, 32'h1234_5678, '0, 16'h8000, HINT_LEAVING);
    script.push_back(row);
    row.op    = ROW_CONFIG;
    row.ip    = '1;
    row.ip_ok = 1'b1;
    script.push_back(row);
    row.op    = ROW_PACKET;
    row.typed = 1'b1;
    // Table was emptied by the report: the first insert lands in slot 0.
    row.pkt   = make_pkt(CMD_ACCOUNT, '1, '0, 16'hFFFF, HINT_UNKNOWN);
    row.want  = make_result(KIND_STATUS, '0, '1, '0, 48'hFFFF, '0, 1'b1, 1'b0, 1'b1);
    script.push_back(row);
    row.pkt   = make_pkt(CMD_ACCOUNT, '0, '1, 16'hFFFF, HINT_UNKNOWN_ALT);
    row.want  = make_result(KIND_STATUS, '0, '1, 48'hFFFF, 48'hFFFF, '0, 1'b0, 1'b0, 1'b1);
    script.push_back(row);
    row.typed = 1'b0;
    row.pkt   = make_pkt(CMD_REPORT, '0, '0, '0, HINT_UNKNOWN);
    script.push_back(row);

    // Hold reset once at the start, then release it.
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_gap_pct   = 26;
    recv_stall_pct = 26;
    foreach (script[r]) begin
      if (script[r].op == ROW_CONFIG)
        set_monitor(script[r].ip, script[r].ip_ok, '0);
      else
        send_item(script[r].pkt, script[r].typed, script[r].want);
    end

    // Random phases: cycle through the idling patterns, and through local
    // address settings (both extremes, then random), valid mostly set.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph % 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 45;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 45;
        end
        default: begin
          send_gap_pct   = 26;
          recv_stall_pct = 26;
        end
      endcase
      set_monitor((ph == 0) ? '0 : (ph == 1) ? '1 : $urandom,
                  (ph % 3) != 2, $urandom);

      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        flavor = $urandom_range(9);
        if (flavor < 6) begin
          // Short well-formed burst with many repeat flows.
          run_burst($urandom_range(1, 24), 10);
        end else if (flavor < 8) begin
          // Long burst of mostly new flows: fills the table and overflows.
          run_burst($urandom_range(36, 44), 88);
        end else begin
          // Noise: unrelated packets and stray reports.
          repeat ($urandom_range(1, 6)) send_item(random_pkt(25));
        end
      end
    end

    drain();
    if (mismatches == 0 && flow_results_due.size() == 0)
      $display("ip_flow_byte_accounting: match");
    else
      $display("ip_flow_byte_accounting: mismatch");
    $finish;
  end

endmodule
